// ===== sv/dhtr_pkg.sv =====
package dhtr_pkg;

    // Command codes of an input item
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_EDGE  = 2'd2;

    // Phase codes as seen on the result
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_START = 2'd1;
    localparam logic [1:0] PH_WAIT  = 2'd2;
    localparam logic [1:0] PH_READ  = 2'd3;

    // Configuration register map
    localparam int unsigned ADDR_W = 5;
    localparam int unsigned IDX_W  = 3;
    localparam logic [IDX_W-1:0] REG_START_LOW  = 3'd0;
    localparam logic [IDX_W-1:0] REG_TIMEOUT    = 3'd1;
    localparam logic [IDX_W-1:0] REG_RESP_MIN   = 3'd2;
    localparam logic [IDX_W-1:0] REG_RESP_MAX   = 3'd3;
    localparam logic [IDX_W-1:0] REG_BIT_THRESH = 3'd4;

    localparam logic [7:0]  RST_START_LOW  = 8'd18;
    localparam logic [7:0]  RST_TIMEOUT    = 8'd10;
    localparam logic [15:0] RST_RESP_MIN   = 16'd120;
    localparam logic [15:0] RST_RESP_MAX   = 16'd220;
    localparam logic [15:0] RST_BIT_THRESH = 16'd100;

    localparam logic [7:0] ELAPSED_MAX = 8'd255;
    localparam logic [5:0] FRAME_BITS  = 6'd40;

    typedef struct packed {
        logic [7:0]  start_low_ms;
        logic [7:0]  timeout_ms;
        logic [15:0] response_min;
        logic [15:0] response_max;
        logic [15:0] bit_threshold;
    } cfg_t;

endpackage

// ===== sv/dhtr_if.sv =====
interface dhtr_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [15:0] edge_time;
    logic        line_level;

    modport source (output valid, cmd, edge_time, line_level, input ready);
    modport sink   (input valid, cmd, edge_time, line_level, output ready);
endinterface

interface dhtr_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] phase;
    logic       drive_low;
    logic       clear_timer;
    logic       data_valid;
    logic       read_error;
    logic [7:0] humidity_int;
    logic [7:0] humidity_dec;
    logic [7:0] temperature_int;
    logic [7:0] temperature_dec;

    modport source (output valid, phase, drive_low, clear_timer, data_valid, read_error,
                    humidity_int, humidity_dec, temperature_int, temperature_dec,
                    input ready);
    modport sink   (input valid, phase, drive_low, clear_timer, data_valid, read_error,
                    humidity_int, humidity_dec, temperature_int, temperature_dec,
                    output ready);
endinterface

// ===== sv/dhtr_regs.sv =====
module dhtr_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dhtr_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output dhtr_pkg::cfg_t                cfg
);
    import dhtr_pkg::*;

    cfg_t             cfg_reg;
    logic             wr_en;
    logic [IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign idx    = paddr[ADDR_W-1:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_low_ms  <= RST_START_LOW;
            cfg_reg.timeout_ms    <= RST_TIMEOUT;
            cfg_reg.response_min  <= RST_RESP_MIN;
            cfg_reg.response_max  <= RST_RESP_MAX;
            cfg_reg.bit_threshold <= RST_BIT_THRESH;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_START_LOW:  cfg_reg.start_low_ms  <= pwdata[7:0];
                REG_TIMEOUT:    cfg_reg.timeout_ms    <= pwdata[7:0];
                REG_RESP_MIN:   cfg_reg.response_min  <= pwdata[15:0];
                REG_RESP_MAX:   cfg_reg.response_max  <= pwdata[15:0];
                REG_BIT_THRESH: cfg_reg.bit_threshold <= pwdata[15:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_START_LOW:  prdata = {24'd0, cfg_reg.start_low_ms};
            REG_TIMEOUT:    prdata = {24'd0, cfg_reg.timeout_ms};
            REG_RESP_MIN:   prdata = {16'd0, cfg_reg.response_min};
            REG_RESP_MAX:   prdata = {16'd0, cfg_reg.response_max};
            REG_BIT_THRESH: prdata = {16'd0, cfg_reg.bit_threshold};
            default:        prdata = 32'd0;
        endcase
    end
endmodule

// ===== sv/dhtr_core.sv =====
module dhtr_core (
    input  logic           clk,
    input  logic           rst_n,
    input  dhtr_pkg::cfg_t cfg,
    dhtr_req_if.sink       req,
    dhtr_res_if.source     res
);
    import dhtr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE  = PH_IDLE,
        S_START = PH_START,
        S_WAIT  = PH_WAIT,
        S_READ  = PH_READ
    } phase_t;

    // input stage
    logic        in_valid_reg;
    logic [1:0]  in_cmd_reg;
    logic [15:0] in_time_reg;
    logic        in_level_reg;

    // sensor read state
    phase_t      phase_reg,   phase_next;
    logic [7:0]  elapsed_reg, elapsed_next;
    logic [15:0] stamp_reg,   stamp_next;
    logic [1:0]  step_reg,    step_next;
    logic [5:0]  bits_reg,    bits_next;
    logic [39:0] data_reg,    data_next;

    // result stage
    logic        out_valid_reg;
    logic [1:0]  out_phase_reg;
    logic        out_drive_reg;
    logic        out_clr_reg,  clr_next;
    logic        out_ok_reg,   ok_next;
    logic        out_err_reg,  err_next;
    logic [39:0] out_data_reg;

    logic        advance;
    logic [15:0] width;
    logic        width_ok;
    logic [7:0]  tick_count;
    logic [39:0] shifted;
    logic [7:0]  sum;

    assign advance   = in_valid_reg & (~out_valid_reg | res.ready);
    assign req.ready = ~in_valid_reg | advance;

    assign width      = in_time_reg - stamp_reg;
    assign width_ok   = (width > cfg.response_min) && (width < cfg.response_max);
    assign tick_count = (elapsed_reg < ELAPSED_MAX) ? elapsed_reg + 8'd1 : elapsed_reg;
    assign shifted    = {data_reg[38:0], (width > cfg.bit_threshold)};
    assign sum        = shifted[39:32] + shifted[31:24] + shifted[23:16] + shifted[15:8];

    always_comb
    begin
        phase_next   = phase_reg;
        elapsed_next = elapsed_reg;
        stamp_next   = stamp_reg;
        step_next    = step_reg;
        bits_next    = bits_reg;
        data_next    = data_reg;
        clr_next     = 1'b0;
        ok_next      = 1'b0;
        err_next     = 1'b0;
        unique case (in_cmd_reg)
            CMD_START:
            begin
                data_next    = '0;
                bits_next    = '0;
                step_next    = '0;
                elapsed_next = '0;
                phase_next   = S_START;
            end
            CMD_TICK:
            begin
                if (phase_reg == S_START)
                begin
                    elapsed_next = tick_count;
                    if (tick_count >= cfg.start_low_ms)
                    begin
                        phase_next   = S_WAIT;
                        clr_next     = 1'b1;
                        stamp_next   = '0;
                        elapsed_next = '0;
                        step_next    = '0;
                    end
                end
                else if (phase_reg == S_WAIT || phase_reg == S_READ)
                begin
                    if (elapsed_reg >= cfg.timeout_ms)
                    begin
                        phase_next = S_IDLE;
                        err_next   = 1'b1;
                    end
                    else
                    begin
                        elapsed_next = elapsed_reg + 8'd1;
                    end
                end
            end
            CMD_EDGE:
            begin
                if (phase_reg == S_WAIT)
                begin
                    stamp_next = in_time_reg;
                    if (step_reg == 2'd0 && !in_level_reg)
                    begin
                        step_next = 2'd1;
                    end
                    else if (step_reg == 2'd1 && in_level_reg)
                    begin
                        if (width_ok)
                        begin
                            step_next = 2'd2;
                        end
                        else
                        begin
                            phase_next = S_IDLE;
                            err_next   = 1'b1;
                        end
                    end
                    else if (step_reg == 2'd2 && !in_level_reg)
                    begin
                        if (width_ok)
                        begin
                            phase_next   = S_READ;
                            elapsed_next = '0;
                            bits_next    = '0;
                        end
                        else
                        begin
                            phase_next = S_IDLE;
                            err_next   = 1'b1;
                        end
                    end
                end
                else if (phase_reg == S_READ)
                begin
                    stamp_next = in_time_reg;
                    if (!in_level_reg)
                    begin
                        data_next = shifted;
                        bits_next = bits_reg + 6'd1;
                        if (bits_reg + 6'd1 >= FRAME_BITS)
                        begin
                            ok_next    = (sum == shifted[7:0]);
                            err_next   = (sum != shifted[7:0]);
                            phase_next = S_IDLE;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            in_cmd_reg    <= CMD_TICK;
            in_time_reg   <= '0;
            in_level_reg  <= 1'b0;
            phase_reg     <= S_IDLE;
            elapsed_reg   <= '0;
            stamp_reg     <= '0;
            step_reg      <= '0;
            bits_reg      <= '0;
            data_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_phase_reg <= PH_IDLE;
            out_drive_reg <= 1'b0;
            out_clr_reg   <= 1'b0;
            out_ok_reg    <= 1'b0;
            out_err_reg   <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                in_cmd_reg   <= req.cmd;
                in_time_reg  <= req.edge_time;
                in_level_reg <= req.line_level;
            end
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            if (advance)
            begin
                phase_reg     <= phase_next;
                elapsed_reg   <= elapsed_next;
                stamp_reg     <= stamp_next;
                step_reg      <= step_next;
                bits_reg      <= bits_next;
                data_reg      <= data_next;
                out_phase_reg <= phase_next;
                out_drive_reg <= (phase_next == S_START);
                out_clr_reg   <= clr_next;
                out_ok_reg    <= ok_next;
                out_err_reg   <= err_next;
                out_data_reg  <= data_next;
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign res.valid           = out_valid_reg;
    assign res.phase           = out_phase_reg;
    assign res.drive_low       = out_drive_reg;
    assign res.clear_timer     = out_clr_reg;
    assign res.data_valid      = out_ok_reg;
    assign res.read_error      = out_err_reg;
    assign res.humidity_int    = out_data_reg[39:32];
    assign res.humidity_dec    = out_data_reg[31:24];
    assign res.temperature_int = out_data_reg[23:16];
    assign res.temperature_dec = out_data_reg[15:8];
endmodule

// ===== sv/dht11_single_wire_reader.sv =====
// An accepted item passes through the input register and then the result register. One
// item per cycle unless the sink stalls the result; the state update and checksum add fit
// between the two registers, so the read state machine takes a new item every clock.
// Reset (rst_n low, asynchronous): phase idle, counters and received data zero, both
// stages empty, configuration registers back to 18 / 10 / 120 / 220 / 100.
module dht11_single_wire_reader (
    input  logic                          clk,
    input  logic                          rst_n,
    dhtr_req_if.sink                      req,
    dhtr_res_if.source                    res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dhtr_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import dhtr_pkg::*;

    // Live configuration; software must write it only while no read is in flight (not enforced here).
    cfg_t cfg;

    // APB register bank: start length, timeout, response window, bit threshold.
    dhtr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Read engine: register the item, advance the phase machine
    // (start low -> wait response -> reading), decode bits by high-pulse
    // width, check the checksum on the fortieth falling edge, and hold the
    // result in the output register until the sink takes it.
    dhtr_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .req   (req),
        .res   (res)
    );
endmodule

// ===== sv/dhtr_checker.sv =====
module dhtr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       valid,
    input logic       ready,
    input logic [1:0] phase,
    input logic       drive_low,
    input logic       clear_timer,
    input logic       data_valid,
    input logic       read_error
);
    import dhtr_pkg::*;

    // drive the line exactly while in start low
    a_drive_phase: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> (drive_low == (phase == PH_START)))
        else $error("drive_low does not match phase");

    a_pass_fail: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> !(data_valid && read_error))
        else $error("data_valid and read_error together");

    a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && (data_valid || read_error)) |-> (phase == PH_IDLE))
        else $error("read ended but phase not idle");

    a_clr_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && clear_timer) |-> (phase == PH_WAIT))
        else $error("clear_timer outside wait response");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && !ready) |=> (valid && $stable(phase) && $stable(read_error)))
        else $error("stalled item changed");
endmodule

bind dht11_single_wire_reader dhtr_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .valid       (res.valid),
    .ready       (res.ready),
    .phase       (res.phase),
    .drive_low   (res.drive_low),
    .clear_timer (res.clear_timer),
    .data_valid  (res.data_valid),
    .read_error  (res.read_error)
);
